### rtl/core/extended_gcd_unit_core_defines.svh
// ----------------------------------------------------------------------------
// extended gcd unit assertion macros
// shared check forms for the extended gcd core, clocked on i_clk and
// disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef EXTENDED_GCD_UNIT_CORE_DEFINES_SVH
`define EXTENDED_GCD_UNIT_CORE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define EGCD_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("egcd: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define EGCD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("egcd: next-cycle check failed");

`endif

### rtl/core/egcd_pkg.sv
// ----------------------------------------------------------------------------
// extended gcd package
// widths, coefficient constants and sequencer states of the extended gcd core
// ----------------------------------------------------------------------------
package egcd_pkg;

    // default operand width and fixed result widths
    localparam int DEF_OPERAND_W = 64;
    localparam int COEF_W        = 64;
    localparam int GCD_W         = 63;

    // coefficient constants
    localparam logic [COEF_W-1:0] COEF_ZERO      = '0;
    localparam logic [COEF_W-1:0] COEF_ONE       = COEF_W'(1);
    localparam logic [COEF_W-1:0] COEF_MINUS_ONE = '1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIV,
        ST_FIX,
        ST_UPD,
        ST_FINAL
    } t_egcd_state;

endpackage

### rtl/core/extended_gcd_unit_core.sv
// ----------------------------------------------------------------------------
// extended gcd unit core
// extended euclidean algorithm on two signed operands: gcd and bezout
// coefficients x, y with a*x + b*y = gcd, computed by one shared radix-2
// divider whose quotient bits drive the coefficient products directly
// ----------------------------------------------------------------------------
// usage
//   input channel : i_valid / o_ready with i_first_operand, i_second_operand.
//                   o_ready is high only while the sequencer is idle; one item
//                   is worked on at a time.
//   output channel: o_valid / i_ready with o_divisor_result, o_coef_first,
//                   o_coef_second, held in an output register.
//   operands      : the low OPERAND_WIDTH bits are two's complement; the most
//                   negative value is saturated to its neighbor.
//   sequence      : each euclid step (up to about 92 for 64-bit operands) is a
//                   test state, the restoring divider that yields OPERAND_WIDTH
//                   quotient bits, a correction and an update state; a last
//                   test finds a zero remainder and leads to the final state.
//   overlap       : a new item is accepted only back in idle, after the last
//                   result is loaded into the output register; the next item can be
//                   taken while a finished result still waits for the receiver.
//   stall         : if the output register is still full when a new result is
//                   ready, the sequencer holds that result until it drains.
//   reset         : synchronous, active low; returns to idle, output empty.
// ----------------------------------------------------------------------------
`include "extended_gcd_unit_core_defines.svh"

module extended_gcd_unit_core #(
    parameter int OPERAND_WIDTH = egcd_pkg::DEF_OPERAND_W
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic signed [63:0]                i_first_operand,
    input  logic signed [63:0]                i_second_operand,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [egcd_pkg::GCD_W-1:0]        o_divisor_result,
    output logic signed [egcd_pkg::COEF_W-1:0] o_coef_first,
    output logic signed [egcd_pkg::COEF_W-1:0] o_coef_second
);
    import egcd_pkg::*;

    localparam int W     = OPERAND_WIDTH;
    localparam int CNT_W = $clog2(W);
    localparam logic [W-1:0]     OP_MIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(W - 1);

    // sequencer
    t_egcd_state r_state, n_state;

    // euclid working registers
    logic signed [W-1:0]  r_major, n_major;
    logic signed [W-1:0]  r_minor, n_minor;
    logic [COEF_W-1:0]    r_u_prior, n_u_prior;
    logic [COEF_W-1:0]    r_v_prior, n_v_prior;
    logic [COEF_W-1:0]    r_u_now, n_u_now;
    logic [COEF_W-1:0]    r_v_now, n_v_now;
    logic                 r_parity, n_parity;
    logic [1:0]           r_steps, n_steps;
    logic                 r_swapped, n_swapped;

    // divider and product accumulators
    logic [W-1:0]         r_div_rem, n_div_rem;
    logic [W-1:0]         r_div_dvd, n_div_dvd;
    logic [W-1:0]         r_div_dvs, n_div_dvs;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [COEF_W-1:0]    r_acc_u, n_acc_u;
    logic [COEF_W-1:0]    r_acc_v, n_acc_v;

    // output register
    logic                 r_out_valid, n_out_valid;
    logic [GCD_W-1:0]     r_out_gcd, n_out_gcd;
    logic [COEF_W-1:0]    r_out_x, n_out_x;
    logic [COEF_W-1:0]    r_out_y, n_out_y;

    // control decoded from state
    logic                 c_accept;
    logic                 c_start_div;
    logic                 c_div_step;
    logic                 c_fix;
    logic                 c_upd;
    logic                 c_out_load;

    // datapath helpers
    logic [W-1:0]         a_sat, b_sat, a_mag, b_mag;
    logic [W-1:0]         major_mag, minor_mag;
    logic [W-1:0]         rem_sh;
    logic [W:0]           rem_diff;
    logic                 q_bit;
    logic                 fix_corr;
    logic                 q_neg;
    logic [COEF_W-1:0]    v_prior_fix;
    logic [COEF_W-1:0]    x_fin, y_fin;

    // input saturation and magnitudes
    always_comb begin
        a_sat = (i_first_operand[W-1:0] == OP_MIN) ? OP_MIN + 1'b1 : i_first_operand[W-1:0];
        b_sat = (i_second_operand[W-1:0] == OP_MIN) ? OP_MIN + 1'b1 : i_second_operand[W-1:0];
        a_mag = a_sat[W-1] ? ~a_sat + 1'b1 : a_sat;
        b_mag = b_sat[W-1] ? ~b_sat + 1'b1 : b_sat;
        major_mag = r_major[W-1] ? ~r_major + 1'b1 : r_major;
        minor_mag = r_minor[W-1] ? ~r_minor + 1'b1 : r_minor;
    end

    // restoring divider step and sign handling of the euclidean quotient
    always_comb begin
        rem_sh   = {r_div_rem[W-2:0], r_div_dvd[W-1]};
        rem_diff = {1'b0, rem_sh} - {1'b0, r_div_dvs};
        q_bit    = ~rem_diff[W];
        fix_corr = r_major[W-1] && (r_div_rem != '0);
        q_neg    = r_major[W-1] ^ r_minor[W-1];
    end

    // final coefficient signs from step parity, one-step sign fix
    always_comb begin
        v_prior_fix = (r_steps == 2'd1 && r_major[W-1]) ? ~r_v_prior + 1'b1 : r_v_prior;
        if (r_steps == 2'd0) begin
            x_fin = r_major[W-1] ? COEF_MINUS_ONE : COEF_ONE;
            y_fin = COEF_ZERO;
        end else begin
            x_fin = r_parity ? ~r_u_prior + 1'b1 : r_u_prior;
            y_fin = r_parity ? ~v_prior_fix + 1'b1 : v_prior_fix;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_valid) n_state = ST_TEST;
            ST_TEST:  n_state = (r_minor == '0) ? ST_FINAL : ST_DIV;
            ST_DIV:   if (r_cnt == CNT_LAST) n_state = ST_FIX;
            ST_FIX:   n_state = ST_UPD;
            ST_UPD:   n_state = ST_TEST;
            ST_FINAL: if (!r_out_valid || i_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_ready     = 1'b0;
        c_start_div = 1'b0;
        c_div_step  = 1'b0;
        c_fix       = 1'b0;
        c_upd       = 1'b0;
        c_out_load  = 1'b0;
        case (r_state)
            ST_IDLE:  o_ready = 1'b1;
            ST_TEST:  c_start_div = (r_minor != '0);
            ST_DIV:   c_div_step = 1'b1;
            ST_FIX:   c_fix = 1'b1;
            ST_UPD:   c_upd = 1'b1;
            ST_FINAL: c_out_load = !r_out_valid || i_ready;
            default:  o_ready = 1'b0;
        endcase
        c_accept = o_ready && i_valid;
    end

    // working register updates
    always_comb begin
        n_major   = r_major;
        n_minor   = r_minor;
        n_u_prior = r_u_prior;
        n_v_prior = r_v_prior;
        n_u_now   = r_u_now;
        n_v_now   = r_v_now;
        n_parity  = r_parity;
        n_steps   = r_steps;
        n_swapped = r_swapped;
        n_div_rem = r_div_rem;
        n_div_dvd = r_div_dvd;
        n_div_dvs = r_div_dvs;
        n_cnt     = r_cnt;
        n_acc_u   = r_acc_u;
        n_acc_v   = r_acc_v;

        // load operands, larger magnitude first
        if (c_accept) begin
            n_swapped = (a_mag < b_mag);
            n_major   = (a_mag < b_mag) ? b_sat : a_sat;
            n_minor   = (a_mag < b_mag) ? a_sat : b_sat;
            n_u_prior = COEF_ONE;
            n_v_prior = COEF_ZERO;
            n_u_now   = COEF_ZERO;
            n_v_now   = COEF_MINUS_ONE;
            n_parity  = 1'b0;
            n_steps   = 2'd0;
        end

        // start one division of the magnitudes
        if (c_start_div) begin
            n_div_rem = '0;
            n_div_dvd = major_mag;
            n_div_dvs = minor_mag;
            n_cnt     = '0;
            n_acc_u   = COEF_ZERO;
            n_acc_v   = COEF_ZERO;
        end

        // one quotient bit, horner accumulation of quotient times coefficient
        if (c_div_step) begin
            n_div_rem = q_bit ? rem_diff[W-1:0] : rem_sh;
            n_div_dvd = {r_div_dvd[W-2:0], 1'b0};
            n_cnt     = r_cnt + 1'b1;
            n_acc_u   = {r_acc_u[COEF_W-2:0], 1'b0} + (q_bit ? r_u_now : COEF_ZERO);
            n_acc_v   = {r_acc_v[COEF_W-2:0], 1'b0} + (q_bit ? r_v_now : COEF_ZERO);
        end

        // floor correction for a negative dividend with nonzero remainder
        if (c_fix) begin
            n_div_rem = fix_corr ? r_div_dvs - r_div_rem : r_div_rem;
            n_acc_u   = r_acc_u + (fix_corr ? r_u_now : COEF_ZERO);
            n_acc_v   = r_acc_v + (fix_corr ? r_v_now : COEF_ZERO);
        end

        // euclid step: shift remainders and coefficient pairs
        if (c_upd) begin
            n_major   = r_minor;
            n_minor   = r_div_rem;
            n_u_prior = r_u_now;
            n_v_prior = r_v_now;
            n_u_now   = q_neg ? r_u_prior - r_acc_u : r_u_prior + r_acc_u;
            n_v_now   = q_neg ? r_v_prior - r_acc_v : r_v_prior + r_acc_v;
            n_parity  = ~r_parity;
            n_steps   = (r_steps == 2'd2) ? r_steps : r_steps + 1'b1;
        end
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid;
        n_out_gcd   = r_out_gcd;
        n_out_x     = r_out_x;
        n_out_y     = r_out_y;
        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (c_out_load) begin
            n_out_valid = 1'b1;
            n_out_gcd   = GCD_W'(major_mag);
            n_out_x     = r_swapped ? y_fin : x_fin;
            n_out_y     = r_swapped ? x_fin : y_fin;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_steps     <= 2'd0;
            r_parity    <= 1'b0;
            r_swapped   <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_steps     <= n_steps;
            r_parity    <= n_parity;
            r_swapped   <= n_swapped;
            r_cnt       <= n_cnt;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_major   <= '0;
            r_minor   <= '0;
            r_u_prior <= COEF_ONE;
            r_v_prior <= COEF_ZERO;
            r_u_now   <= COEF_ZERO;
            r_v_now   <= COEF_MINUS_ONE;
        end else begin
            r_major   <= n_major;
            r_minor   <= n_minor;
            r_u_prior <= n_u_prior;
            r_v_prior <= n_v_prior;
            r_u_now   <= n_u_now;
            r_v_now   <= n_v_now;
        end
        r_div_rem <= n_div_rem;
        r_div_dvd <= n_div_dvd;
        r_div_dvs <= n_div_dvs;
        r_acc_u   <= n_acc_u;
        r_acc_v   <= n_acc_v;
        r_out_gcd <= n_out_gcd;
        r_out_x   <= n_out_x;
        r_out_y   <= n_out_y;
    end

    // port drive
    assign o_valid          = r_out_valid;
    assign o_divisor_result = r_out_gcd;
    assign o_coef_first     = r_out_x;
    assign o_coef_second    = r_out_y;

    // checks
    `EGCD_ASSERT_NEXT(a_accept_starts_test, i_valid && o_ready, r_state == ST_TEST)
    `EGCD_ASSERT_SAME(a_div_rem_below_dvs, r_state == ST_DIV, r_div_rem < r_div_dvs)
    `EGCD_ASSERT_SAME(a_minor_nonneg_after_step, r_steps != 2'd0, !r_minor[W-1])
    `EGCD_ASSERT_SAME(a_final_minor_zero, r_state == ST_FINAL, r_minor == '0)

endmodule
